// File: design/assert_macros.svh
// Assertion macros for the checker file of the LCD nibble sequencer.
// Needs nothing else; the checker includes this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// A same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/lcdns_pkg.sv
// Package of the character-LCD nibble sequencer: codes, job and config types.
// Used by every design module of the block; depends on nothing.
package lcdns_pkg;

  localparam int DEF_VISIBLE_COLUMNS = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_ADDR_W          = 4;
  localparam int STEP_W              = 5;

  localparam logic [7:0]  RESET_FUNCTION_SET    = 8'h28;
  localparam logic [7:0]  RESET_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0]  RESET_ENTRY_MODE      = 8'h06;

  localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
  localparam logic [7:0]  CLEAR_INSTR     = 8'h01;
  localparam logic [7:0]  LINE1_BASE      = 8'h80;
  localparam logic [7:0]  LINE2_BASE      = 8'hC0;
  localparam logic [7:0]  CGRAM_BASE      = 8'h40;
  localparam logic [1:0]  SECOND_LINE_ROW = 2'd2;
  localparam logic [12:0] WAKE_WAIT       = 13'd5000;
  localparam logic [12:0] CLEAR_INIT_WAIT = 13'd3000;
  localparam logic [12:0] CLEAR_ALL_WAIT  = 13'd1600;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CMD   = 3'd1,
    OP_CHAR  = 3'd2,
    OP_PLACE = 3'd3,
    OP_CLEAR = 3'd4,
    OP_GLYPH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    REG_FUNCTION_SET    = 2'd0,
    REG_DISPLAY_CONTROL = 2'd1,
    REG_ENTRY_MODE      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    JOB_INIT,
    JOB_CMD,
    JOB_CHAR,
    JOB_PLACE,
    JOB_CLEAR,
    JOB_GLYPH
  } job_kind_t;

  typedef struct packed {
    logic [7:0] function_set_word;
    logic [7:0] display_control_word;
    logic [7:0] entry_mode_word;
  } cfg_t;

  // For an init job byte_a/byte_b/rows[7:0] hold the three power-up words.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [63:0] rows;
    logic        initialized;
  } job_t;

endpackage

// File: design/lcdns_ifs.sv
// Valid/ready channel interfaces of the LCD nibble sequencer: request and strobe.
// Depends on nothing but the field widths given here.
interface lcdns_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  data_byte;
  logic [1:0]  row;
  logic [3:0]  position;
  logic [63:0] glyph_rows;

  modport source (output valid, op, data_byte, row, position, glyph_rows, input ready);
  modport sink   (input valid, op, data_byte, row, position, glyph_rows, output ready);
endinterface

interface lcdns_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  nibble;
  logic        register_select;
  logic [12:0] wait_after_us;
  logic        last;
  logic        initialized;

  modport source (output valid, nibble, register_select, wait_after_us, last, initialized,
                  input ready);
  modport sink   (input valid, nibble, register_select, wait_after_us, last, initialized,
                  output ready);
endinterface

// File: design/char_lcd_nibble_sequencer.sv
// A taken request is written into the job queue; its first strobe then goes into the
// output register. Throughput: one strobe per cycle unless the output stalls; each
// request gives 2 to 20 strobes (12 for power-up); a two-job queue keeps taking requests.
// Reset: synchronous, active low; sets the config words to 0x28, 0x0C and 0x06, clears the
// initialised flag, the queue and the output valid; there is no clearing pass.
module char_lcd_nibble_sequencer #(
  parameter int VISIBLE_COLUMNS = lcdns_pkg::DEF_VISIBLE_COLUMNS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lcdns_in_if.sink                         in_ch,
  lcdns_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcdns_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lcdns_pkg::*;

  // Register writes complete in the access cycle; there are no wait states.
  cfg_t cfg;
  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  assign pready = 1'b1;

  lcdns_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The front end classifies each request and snapshots the power-up words,
  // so later register writes never touch a job already queued.
  lcdns_front #(
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  lcdns_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // The back end pops a job together with its final strobe, so a queued next job
  // can start in the cycle after, unless the output stalls.
  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_valid (!q_empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// File: design/lcdns_regs.sv
// APB-style register file holding the three power-up instruction words.
// Depends on lcdns_pkg.
module lcdns_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcdns_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output lcdns_pkg::cfg_t                  cfg
);
  import lcdns_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set_word    <= RESET_FUNCTION_SET;
      cfg_r.display_control_word <= RESET_DISPLAY_CONTROL;
      cfg_r.entry_mode_word      <= RESET_ENTRY_MODE;
    end else if (wr_en) begin
      unique case (idx)
        REG_FUNCTION_SET:    cfg_r.function_set_word    <= pwdata[7:0];
        REG_DISPLAY_CONTROL: cfg_r.display_control_word <= pwdata[7:0];
        REG_ENTRY_MODE:      cfg_r.entry_mode_word      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FUNCTION_SET:    prdata = {24'd0, cfg_r.function_set_word};
      REG_DISPLAY_CONTROL: prdata = {24'd0, cfg_r.display_control_word};
      REG_ENTRY_MODE:      prdata = {24'd0, cfg_r.entry_mode_word};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// File: design/lcdns_front.sv
// Front end: accepts requests, drops those that give no strobes and turns the
// rest into jobs for the queue. Depends on lcdns_pkg and lcdns_in_if.
module lcdns_front #(
  parameter int VISIBLE_COLUMNS = lcdns_pkg::DEF_VISIBLE_COLUMNS
) (
  input  logic            clk,
  input  logic            rst_n,
  lcdns_in_if.sink        in_ch,
  input  lcdns_pkg::cfg_t cfg,
  input  logic            q_full,
  output logic            push,
  output lcdns_pkg::job_t job
);
  import lcdns_pkg::*;

  logic       init_done_r;
  logic       keep;
  logic       accept;
  logic [7:0] line_base;
  op_t        op;

  assign op        = op_t'(in_ch.op);
  assign in_ch.ready = !q_full;
  assign accept    = in_ch.valid && !q_full;
  assign push      = accept && keep;
  assign line_base = (in_ch.row == SECOND_LINE_ROW) ? LINE2_BASE : LINE1_BASE;

  always_comb begin
    job             = '0;
    job.rows        = in_ch.glyph_rows;
    job.byte_a      = in_ch.data_byte;
    job.initialized = init_done_r;
    keep            = 1'b0;
    unique case (op)
      OP_INIT: begin
        keep            = 1'b1;
        job.kind        = JOB_INIT;
        job.byte_a      = cfg.function_set_word;
        job.byte_b      = cfg.display_control_word;
        job.rows        = {56'd0, cfg.entry_mode_word};
        job.initialized = 1'b1;
      end
      OP_CMD: begin
        keep     = 1'b1;
        job.kind = JOB_CMD;
      end
      OP_CHAR: begin
        keep     = 1'b1;
        job.kind = JOB_CHAR;
      end
      OP_PLACE: begin
        keep       = int'(in_ch.position) < VISIBLE_COLUMNS;
        job.kind   = JOB_PLACE;
        job.byte_a = line_base + {4'd0, in_ch.position};
        job.byte_b = in_ch.data_byte;
      end
      OP_CLEAR: begin
        keep     = 1'b1;
        job.kind = JOB_CLEAR;
      end
      OP_GLYPH: begin
        keep       = !in_ch.position[3];
        job.kind   = JOB_GLYPH;
        job.byte_a = CGRAM_BASE | {2'd0, in_ch.position[2:0], 3'd0};
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
    end else if (accept && op == OP_INIT) begin
      init_done_r <= 1'b1;
    end
  end

endmodule

// File: design/lcdns_queue.sv
// Short job queue between the front end and the strobe sequencer.
// Depends on lcdns_pkg.
module lcdns_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdns_pkg::job_t wr_job,
  input  logic            pop,
  output lcdns_pkg::job_t rd_job,
  output logic            full,
  output logic            empty
);
  import lcdns_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;

  assign full   = count_r == (AW + 1)'(QUEUE_DEPTH);
  assign empty  = count_r == '0;
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// File: design/lcdns_back.sv
// Back end: walks the head job one strobe per cycle, when the output is not
// stalled, into the output register. Depends on lcdns_pkg and lcdns_out_if.
module lcdns_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lcdns_pkg::job_t job,
  input  logic            job_valid,
  output logic            pop,
  lcdns_out_if.source     out_ch
);
  import lcdns_pkg::*;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [12:0] wait_us;
    logic        last;
  } strobe_t;

  logic [STEP_W-1:0] step_r, step_nxt, init_idx;
  logic [3:0]        byte_idx;
  logic [2:0]        row_idx;
  logic              lo;
  logic [7:0]        cur_byte;
  logic              load;
  strobe_t           s;
  logic              out_valid_r;
  strobe_t           out_r;
  logic              init_flag_r;

  assign lo       = step_r[0];
  assign byte_idx = step_r[STEP_W-1:1];
  assign row_idx  = 3'(byte_idx - 4'd1);
  assign init_idx = step_r - STEP_W'(4);

  always_comb begin
    cur_byte  = job.byte_a;
    s.rs      = 1'b0;
    s.wait_us = '0;
    s.last    = lo;
    unique case (job.kind)
      JOB_INIT: begin
        // Byte order after the wake nibbles: function set, display control,
        // clear, entry mode.
        unique case (init_idx[2:1])
          2'd0:    cur_byte = job.byte_a;
          2'd1:    cur_byte = job.byte_b;
          2'd2:    cur_byte = CLEAR_INSTR;
          default: cur_byte = job.rows[7:0];
        endcase
        s.last = step_r == STEP_W'(11);
        if (init_idx == STEP_W'(5)) begin
          s.wait_us = CLEAR_INIT_WAIT;
        end
      end
      JOB_CMD: cur_byte = job.byte_a;
      JOB_CHAR: begin
        cur_byte = job.byte_a;
        s.rs     = 1'b1;
      end
      JOB_PLACE: begin
        cur_byte = byte_idx[0] ? job.byte_b : job.byte_a;
        s.rs     = byte_idx[0];
        s.last   = step_r == STEP_W'(3);
      end
      JOB_CLEAR: begin
        cur_byte  = CLEAR_INSTR;
        s.wait_us = lo ? CLEAR_ALL_WAIT : 13'd0;
      end
      JOB_GLYPH: begin
        s.last = step_r == STEP_W'(19);
        if (byte_idx == 4'd0) begin
          cur_byte = job.byte_a;
        end else if (byte_idx == 4'd9) begin
          cur_byte = LINE1_BASE;
        end else begin
          cur_byte = job.rows[{row_idx, 3'd0} +: 8];
          s.rs     = 1'b1;
        end
      end
      default: ;
    endcase

    // Bytes leave upper nibble first; init opens with three wake nibbles and
    // a lone upper nibble of the function set word.
    if (job.kind == JOB_INIT && step_r < STEP_W'(3)) begin
      s.nibble  = WAKE_NIBBLE;
      s.wait_us = WAKE_WAIT;
    end else if (job.kind == JOB_INIT && step_r == STEP_W'(3)) begin
      s.nibble = job.byte_a[7:4];
    end else if (job.kind == JOB_INIT) begin
      s.nibble = init_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    end else begin
      s.nibble = lo ? cur_byte[3:0] : cur_byte[7:4];
    end
  end

  assign load     = job_valid && (!out_valid_r || out_ch.ready);
  assign pop      = load && s.last;
  assign step_nxt = s.last ? '0 : step_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= step_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r       <= s;
      init_flag_r <= job.initialized;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.nibble          = out_r.nibble;
  assign out_ch.register_select = out_r.rs;
  assign out_ch.wait_after_us   = out_r.wait_us;
  assign out_ch.last            = out_r.last;
  assign out_ch.initialized     = init_flag_r;

endmodule

// File: design/lcdns_checker.sv
// Port-level checker for the LCD nibble sequencer and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lcdns_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  nibble,
  input logic        register_select,
  input logic [12:0] wait_after_us,
  input logic        last,
  input logic        initialized
);

  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(nibble) && $stable(last) && $stable(wait_after_us))
  `ASSERT_NEXT(a_init_sticky, clk, rst_n, out_valid && initialized, !out_valid || initialized)
  `ASSERT_IMPLIES(a_wake_strobe, clk, rst_n, out_valid && wait_after_us == 13'd5000, nibble == 4'h3 && !register_select && !last)
  `ASSERT_IMPLIES(a_wait_values, clk, rst_n, out_valid, wait_after_us == 13'd0 || wait_after_us == 13'd1600 || wait_after_us == 13'd3000 || wait_after_us == 13'd5000)
  `ASSERT_IMPLIES(a_clear_all_last, clk, rst_n, out_valid && wait_after_us == 13'd1600, last && nibble == 4'h1)

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .nibble          (out_ch.nibble),
  .register_select (out_ch.register_select),
  .wait_after_us   (out_ch.wait_after_us),
  .last            (out_ch.last),
  .initialized     (out_ch.initialized)
);
